@@ rtl/tfan_pkg.sv @@
// ----------------------------------------------------------------------------
// tfan_pkg
// Shared types and constants for the triangle fan texture generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tfan_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned POS_AXES   = 3;
    localparam int unsigned NUM_ROWS   = 4;
    localparam int unsigned ROW_WORDS  = 4;
    localparam int unsigned COEF_WORDS = NUM_ROWS * ROW_WORDS;

    // Item kind carried in the input side-band
    localparam logic ACT_COEFF  = 1'b0;
    localparam logic ACT_VERTEX = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    // What the last pipeline stage does with a vertex
    typedef enum logic [1:0] {
        ROLE_ANCHOR,
        ROLE_PREV,
        ROLE_EMIT
    } t_role;

    // Vertex control and position traveling alongside the projection datapath
    typedef struct packed {
        logic                     valid;
        t_role                    role;
        t_word [POS_AXES-1:0]     pos;   // [0] x, [1] y, [2] z
    } t_vtx_tag;

    // One result; first member is the most significant, so out_x sits lowest
    typedef struct packed {
        t_word light_v;
        t_word light_u;
        t_word tex_v;
        t_word tex_u;
        t_word out_z;
        t_word out_y;
        t_word out_x;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/tfan_proj.sv @@
// ----------------------------------------------------------------------------
// tfan_proj
// Four planar projections of a vertex: multiply stage, sum stage, rounding
// and saturation to Q24.8.
// ----------------------------------------------------------------------------
`default_nettype none

module tfan_proj (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_adv,
    input  wire tfan_pkg::t_vtx_tag                      i_tag,
    input  wire tfan_pkg::t_word [tfan_pkg::COEF_WORDS-1:0] i_coef,
    output tfan_pkg::t_vtx_tag                           o_tag,
    output tfan_pkg::t_word [tfan_pkg::NUM_ROWS-1:0]     o_coord
);

    localparam int unsigned PROD_W  = 2 * tfan_pkg::WORD_W;
    localparam int unsigned SUM_W   = PROD_W + 2;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned OFF_SH  = 8;
    localparam int unsigned SAT_LSB = FRAC_W + tfan_pkg::WORD_W - 1;

    localparam logic [SUM_W-1:0]            ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
    localparam logic [tfan_pkg::WORD_W-1:0] SAT_MAX    = {1'b0, {(tfan_pkg::WORD_W-1){1'b1}}};
    localparam logic [tfan_pkg::WORD_W-1:0] SAT_MIN    = {1'b1, {(tfan_pkg::WORD_W-1){1'b0}}};

    tfan_pkg::t_vtx_tag     r_a_tag;
    tfan_pkg::t_vtx_tag     r_b_tag;
    logic signed [PROD_W-1:0] r_prod [tfan_pkg::NUM_ROWS][tfan_pkg::POS_AXES];
    tfan_pkg::t_word        r_off  [tfan_pkg::NUM_ROWS];
    logic [SUM_W-1:0]       r_sum  [tfan_pkg::NUM_ROWS];
    logic [SUM_W-1:0]       n_sum  [tfan_pkg::NUM_ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag.valid <= 1'b0;
            r_b_tag.valid <= 1'b0;
        end else if (i_adv) begin
            r_a_tag <= i_tag;
            r_b_tag <= r_a_tag;
        end
    end

    // Exact Q40.24 products
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < tfan_pkg::NUM_ROWS; r++) begin
                for (int k = 0; k < tfan_pkg::POS_AXES; k++) begin
                    r_prod[r][k] <= signed'(i_tag.pos[k])
                                  * signed'(i_coef[r*tfan_pkg::ROW_WORDS + k]);
                end
                r_off[r] <= i_coef[r*tfan_pkg::ROW_WORDS + tfan_pkg::POS_AXES];
            end
        end
    end

    // Sum at Q.24, offset aligned up, half LSB of Q24.8 added for round half up
    always_comb begin
        for (int r = 0; r < tfan_pkg::NUM_ROWS; r++) begin
            n_sum[r] = {{(SUM_W-PROD_W){r_prod[r][0][PROD_W-1]}}, r_prod[r][0]}
                     + {{(SUM_W-PROD_W){r_prod[r][1][PROD_W-1]}}, r_prod[r][1]}
                     + {{(SUM_W-PROD_W){r_prod[r][2][PROD_W-1]}}, r_prod[r][2]}
                     + {{(SUM_W-tfan_pkg::WORD_W-OFF_SH){r_off[r][tfan_pkg::WORD_W-1]}},
                        r_off[r], {OFF_SH{1'b0}}}
                     + ROUND_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum <= n_sum;
        end
    end

    // Floor to Q24.8 by dropping the fraction, then clamp
    always_comb begin
        for (int r = 0; r < tfan_pkg::NUM_ROWS; r++) begin
            if ((&r_sum[r][SUM_W-1:SAT_LSB]) || !(|r_sum[r][SUM_W-1:SAT_LSB])) begin
                o_coord[r] = r_sum[r][SAT_LSB:FRAC_W];
            end else if (r_sum[r][SUM_W-1]) begin
                o_coord[r] = SAT_MIN;
            end else begin
                o_coord[r] = SAT_MAX;
            end
        end
    end

    assign o_tag = r_b_tag;

endmodule

`default_nettype wire

@@ rtl/triangle_fan_texgen.sv @@
// ----------------------------------------------------------------------------
// triangle_fan_texgen
// Triangle fan assembly with four planar texture/lightmap projections.
// ----------------------------------------------------------------------------
// A coefficient write, a face's first vertex, its second vertex and a vertex
// dropped before any face start add no stall of their own on the slave side,
// and back-to-back transactions are accepted. Every later vertex emits a fan
// triangle (anchor, previous, current) as three master-side transactions,
// one per cycle while m_axis_tready is high, so the single result port sets
// the pace of a stream of such vertices. Results come out of a four-entry
// result queue, and the slave side stalls only when a finished triangle
// reaches the end of the three-stage projection pipeline and the queue holds
// more than one result. A vertex passes the input, multiply and sum stages
// before its triangle enters the queue. The coefficient table lives
// in sixteen synchronous banks, one per word of an entry, all read at once
// for a vertex; a word written by one transaction is seen by the next. The
// table is not cleared: every word used by a face must be written first.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_fan_texgen #(
    parameter int unsigned TEXINFO_ENTRIES = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // coeff_address[13:0], coeff_value[45:14], pos_x[77:46], pos_y[109:78],
    // pos_z[141:110], texinfo_index[151:142]
    input  wire logic [151:0] s_axis_tdata,
    // action[0], face_start[1]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], tex_u[127:96], tex_v[159:128],
    // light_u[191:160], light_v[223:192]
    output logic [223:0]      m_axis_tdata,
    // last_of_triangle
    output logic              m_axis_tlast
);

    // ------------------------------------------------------------------
    // Field positions in s_axis_tdata
    // ------------------------------------------------------------------
    localparam int unsigned ADDR_W     = 14;
    localparam int unsigned WSEL_W     = 4;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned ADDR_LSB   = 0;
    localparam int unsigned VAL_LSB    = ADDR_LSB + ADDR_W;
    localparam int unsigned POS_LSB    = VAL_LSB + tfan_pkg::WORD_W;
    localparam int unsigned IDX_LSB    = POS_LSB + tfan_pkg::POS_AXES * tfan_pkg::WORD_W;

    // Entry index width; one bit minimum for a single-entry table
    localparam int unsigned ENTRY_W    = (TEXINFO_ENTRIES > 1) ? $clog2(TEXINFO_ENTRIES) : 1;
    localparam int unsigned CMP_W      = 16;
    localparam logic [CMP_W-1:0] ENTRIES_V = CMP_W'(TEXINFO_ENTRIES);

    // texinfo_index modulo the table size by reciprocal multiply, one correction
    localparam int unsigned MOD_SHIFT  = 20;
    localparam int unsigned RECIP_W    = MOD_SHIFT + 1;
    localparam int unsigned QF_W       = IDX_W + RECIP_W;
    localparam int unsigned QN_W       = IDX_W + CMP_W;
    localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'((1 << MOD_SHIFT) / TEXINFO_ENTRIES);

    // Result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned TRI_RES    = 3;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        FAN_IDLE,
        FAN_ANCHOR,
        FAN_RUN
    } t_fan_state;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic                  w_action;
    logic                  w_fstart;
    logic [ADDR_W-1:0]     w_addr;
    tfan_pkg::t_word       w_coeff_value;
    logic [IDX_W-1:0]      w_tex_idx;
    logic                  w_adv;
    logic                  w_acc;

    assign w_action      = s_axis_tuser[0];
    assign w_fstart      = s_axis_tuser[1];
    assign w_addr        = s_axis_tdata[ADDR_LSB +: ADDR_W];
    assign w_coeff_value = s_axis_tdata[VAL_LSB +: tfan_pkg::WORD_W];
    assign w_tex_idx     = s_axis_tdata[IDX_LSB +: IDX_W];
    assign w_acc         = s_axis_tvalid && w_adv;
    assign s_axis_tready = w_adv;

    // ------------------------------------------------------------------
    // Entry selection
    // ------------------------------------------------------------------
    logic [QF_W-1:0]       w_q_full;
    logic [IDX_W-1:0]      w_q;
    logic [QN_W-1:0]       w_qn;
    logic [QN_W-1:0]       w_rem;
    logic [QN_W-1:0]       w_rem_fix;
    logic [ENTRY_W-1:0]    w_mod_ent;

    always_comb begin
        w_q_full  = QF_W'(w_tex_idx) * QF_W'(MOD_RECIP);
        w_q       = w_q_full[MOD_SHIFT +: IDX_W];
        w_qn      = QN_W'(w_q) * QN_W'(ENTRIES_V);
        w_rem     = QN_W'(w_tex_idx) - w_qn;
        // estimate is at most one short of the quotient
        w_rem_fix = (w_rem >= QN_W'(ENTRIES_V)) ? (w_rem - QN_W'(ENTRIES_V)) : w_rem;
        w_mod_ent = ENTRY_W'(w_rem_fix);
    end

    // ------------------------------------------------------------------
    // Fan sequencing: role of each vertex, latched face entry
    // ------------------------------------------------------------------
    t_fan_state            r_fan;
    t_fan_state            n_fan;
    logic [ENTRY_W-1:0]    r_face_entry;
    logic [ENTRY_W-1:0]    n_face_entry;
    logic [ENTRY_W-1:0]    w_rd_ent;
    tfan_pkg::t_vtx_tag    r_s1_tag;
    tfan_pkg::t_vtx_tag    n_s1_tag;

    always_comb begin
        n_fan          = r_fan;
        n_face_entry   = r_face_entry;
        n_s1_tag.valid = 1'b0;
        n_s1_tag.role  = tfan_pkg::ROLE_EMIT;
        for (int k = 0; k < tfan_pkg::POS_AXES; k++) begin
            n_s1_tag.pos[k] = s_axis_tdata[POS_LSB + k*tfan_pkg::WORD_W +: tfan_pkg::WORD_W];
        end
        // a face start reads the new entry in the same cycle
        w_rd_ent = (w_fstart) ? w_mod_ent : r_face_entry;

        if (s_axis_tvalid && (w_action == tfan_pkg::ACT_VERTEX)) begin
            if (w_fstart) begin
                n_s1_tag.valid = 1'b1;
                n_s1_tag.role  = tfan_pkg::ROLE_ANCHOR;
                n_fan          = FAN_ANCHOR;
                n_face_entry   = w_mod_ent;
            end else begin
                unique case (r_fan)
                    FAN_IDLE: begin
                        // drop: no face open yet
                        n_s1_tag.valid = 1'b0;
                    end
                    FAN_ANCHOR: begin
                        n_s1_tag.valid = 1'b1;
                        n_s1_tag.role  = tfan_pkg::ROLE_PREV;
                        n_fan          = FAN_RUN;
                    end
                    FAN_RUN: begin
                        n_s1_tag.valid = 1'b1;
                        n_s1_tag.role  = tfan_pkg::ROLE_EMIT;
                    end
                    default: begin
                        n_fan = FAN_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan          <= FAN_IDLE;
            r_face_entry   <= '0;
            r_s1_tag.valid <= 1'b0;
        end else if (w_adv) begin
            r_fan        <= n_fan;
            r_face_entry <= n_face_entry;
            r_s1_tag     <= n_s1_tag;
        end
    end

    // ------------------------------------------------------------------
    // Coefficient table: one bank per word of an entry
    // ------------------------------------------------------------------
    logic                  w_wr_en;
    logic [WSEL_W-1:0]     w_wr_word;
    logic [ENTRY_W-1:0]    w_wr_ent;
    tfan_pkg::t_word [tfan_pkg::COEF_WORDS-1:0] w_coef;

    assign w_wr_word = w_addr[WSEL_W-1:0];
    assign w_wr_ent  = ENTRY_W'(w_addr[ADDR_W-1:WSEL_W]);
    // drop writes past the end of a short table
    assign w_wr_en   = w_acc && (w_action == tfan_pkg::ACT_COEFF)
                    && (CMP_W'(w_addr[ADDR_W-1:WSEL_W]) < ENTRIES_V);

    for (genvar b = 0; b < tfan_pkg::COEF_WORDS; b++) begin : g_bank
        tfan_pkg::t_word r_bank [TEXINFO_ENTRIES];
        tfan_pkg::t_word r_rd;

        always_ff @(posedge i_clk) begin
            if (w_wr_en && (w_wr_word == WSEL_W'(b))) begin
                r_bank[w_wr_ent] <= w_coeff_value;
            end
            if (w_adv) begin
                r_rd <= r_bank[w_rd_ent];
            end
        end

        assign w_coef[b] = r_rd;
    end

    // ------------------------------------------------------------------
    // Projection pipeline
    // ------------------------------------------------------------------
    tfan_pkg::t_vtx_tag                        w_b_tag;
    tfan_pkg::t_word [tfan_pkg::NUM_ROWS-1:0]  w_coord;

    tfan_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_tag   (r_s1_tag),
        .i_coef  (w_coef),
        .o_tag   (w_b_tag),
        .o_coord (w_coord)
    );

    // ------------------------------------------------------------------
    // Retire: update anchor/previous, push triangles into the result queue
    // ------------------------------------------------------------------
    tfan_pkg::t_result     w_cur;
    tfan_pkg::t_result     r_anchor;
    tfan_pkg::t_result     r_prev;
    tfan_pkg::t_result     r_fifo [FIFO_DEPTH];
    logic                  r_last [FIFO_DEPTH];
    logic [PTR_W-1:0]      r_wptr;
    logic [PTR_W-1:0]      r_rptr;
    logic [CNT_W-1:0]      r_cnt;
    logic                  w_retire;
    logic                  w_push;
    logic                  w_pop;

    always_comb begin
        w_cur.out_x   = w_b_tag.pos[0];
        w_cur.out_y   = w_b_tag.pos[1];
        w_cur.out_z   = w_b_tag.pos[2];
        w_cur.tex_u   = w_coord[0];
        w_cur.tex_v   = w_coord[1];
        w_cur.light_u = w_coord[2];
        w_cur.light_v = w_coord[3];
    end

    // Hold the pipeline while a triangle waits for three free queue slots
    assign w_adv    = !(w_b_tag.valid && (w_b_tag.role == tfan_pkg::ROLE_EMIT)
                        && (r_cnt > CNT_W'(FIFO_DEPTH - TRI_RES)));
    assign w_retire = w_adv && w_b_tag.valid;
    assign w_push   = w_retire && (w_b_tag.role == tfan_pkg::ROLE_EMIT);
    assign w_pop    = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_retire) begin
            case (w_b_tag.role)
                tfan_pkg::ROLE_ANCHOR: begin
                    r_anchor <= w_cur;
                end
                tfan_pkg::ROLE_PREV: begin
                    r_prev <= w_cur;
                end
                tfan_pkg::ROLE_EMIT: begin
                    r_fifo[r_wptr]              <= r_anchor;
                    r_last[r_wptr]              <= 1'b0;
                    r_fifo[r_wptr + PTR_W'(1)]  <= r_prev;
                    r_last[r_wptr + PTR_W'(1)]  <= 1'b0;
                    r_fifo[r_wptr + PTR_W'(2)]  <= w_cur;
                    r_last[r_wptr + PTR_W'(2)]  <= 1'b1;
                    // advance the fan edge
                    r_prev                      <= w_cur;
                end
                default: begin
                    r_prev <= r_prev;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + PTR_W'(TRI_RES);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_cnt <= r_cnt + (w_push ? CNT_W'(TRI_RES) : CNT_W'(0))
                           - (w_pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_fifo[r_rptr];
    assign m_axis_tlast  = r_last[r_rptr];

`ifndef SYNTH
    // Queue occupancy never exceeds its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A pushed triangle ends with the current vertex flagged last
    a_tri_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_last[r_wptr - PTR_W'(1)] && !r_last[r_wptr - PTR_W'(2)]))
        else $error("triangle last flag misplaced");

    // Coefficient writes and vertices before any face start never enter the pipeline
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready
         && ((w_action == tfan_pkg::ACT_COEFF) || (!w_fstart && (r_fan == FAN_IDLE))))
        |=> !r_s1_tag.valid)
        else $error("non-vertex transaction entered the pipeline");
`endif

endmodule

`default_nettype wire
